@@ rtl/tss_pkg.sv @@
// Task slot scheduler package: phase, action and command codes, the queue
// entry and slot record layouts, and the back-end state encoding.
// No dependencies.
package tss_pkg;

    typedef enum logic [2:0] {
        PH_NEW     = 3'd0,
        PH_RUN     = 3'd1,
        PH_DELAY_T = 3'd2,
        PH_DELAY_C = 3'd3,
        PH_DELAY_M = 3'd4,
        PH_SLEEP   = 3'd5,
        PH_END     = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        ACT_INIT    = 3'd0,
        ACT_PAYLOAD = 3'd1,
        ACT_CLEAN   = 3'd2,
        ACT_DONE    = 3'd3,
        ACT_LOADED  = 3'd4,
        ACT_REFUSED = 3'd5,
        ACT_SET     = 3'd6
    } t_action;

    typedef enum logic [1:0] {
        K_TICK = 2'd0,
        K_LOAD = 2'd1,
        K_SET  = 2'd2
    } t_kind;

    localparam logic [1:0] FN_TICK = 2'd0;
    localparam logic [1:0] FN_LOAD = 2'd1;
    localparam logic [1:0] FN_SET  = 2'd2;

    localparam logic [2:0] NS_KEEP = 3'd7;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] delta;
        logic [31:0] rt;
        logic [3:0]  tslot;
        logic        apply;
        logic [2:0]  nstate;
        logic [31:0] wval;
    } t_cmd;

    typedef struct packed {
        t_phase      phase;
        logic [31:0] wait_amt;
        logic [31:0] elapsed;
        logic [31:0] tid;
    } t_slot_rec;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COUNT,
        ST_TICK_RD,
        ST_TICK_EX,
        ST_DONE,
        ST_LOAD_SCAN,
        ST_LOAD_FIN,
        ST_SET_RD,
        ST_SET_EX
    } t_bstate;

endpackage

@@ rtl/task_slot_scheduler.sv @@
// Task slot scheduler top level: slot-count register over tss_front and tss_back.
// The back end runs one queued command at a time, waiting on output stalls:
// a tick walks the managed slots, a load scans for a free slot and a set-state
// reads the target slot. The two-entry queue takes two more transfers meanwhile.
// Reset clears control and occupancy and sets the id counter to one; the slot RAM
// is left as is.
module task_slot_scheduler #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_time_delta,
    input  logic [31:0] i_real_time,
    input  logic [3:0]  i_target_slot,
    input  logic [2:0]  i_new_state,
    input  logic [31:0] i_wait_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_action,
    output logic [3:0]  o_out_slot,
    output logic [31:0] o_task_id,
    output logic [31:0] o_elapsed,
    output logic [4:0]  o_occupied_count,
    output logic        o_last
);
    import tss_pkg::*;

    logic [4:0] r_slots_in_use;
    logic       w_q_valid;
    logic       w_q_pop;
    t_cmd       w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_in_use <= 5'd16;
        end else if (i_cfg_we) begin
            r_slots_in_use <= i_cfg_wdata;
        end
    end

    tss_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_time_delta  (i_time_delta),
        .i_real_time   (i_real_time),
        .i_target_slot (i_target_slot),
        .i_new_state   (i_new_state),
        .i_wait_value  (i_wait_value),
        .o_q_valid     (w_q_valid),
        .o_cmd         (w_cmd),
        .i_q_pop       (w_q_pop)
    );

    tss_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_slots_in_use   (r_slots_in_use),
        .i_q_valid        (w_q_valid),
        .i_cmd            (w_cmd),
        .o_q_pop          (w_q_pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_action         (o_action),
        .o_out_slot       (o_out_slot),
        .o_task_id        (o_task_id),
        .o_elapsed        (o_elapsed),
        .o_occupied_count (o_occupied_count),
        .o_last           (o_last)
    );

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("queue popped while empty");

    a_loaded_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_action == ACT_LOADED) |-> (o_task_id != '0 && o_last))
        else $error("loaded task carries id zero or is not final");

    a_summary_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_action == ACT_DONE || o_action == ACT_REFUSED))
        |-> (o_last && o_task_id == '0 && o_elapsed == '0 && o_out_slot == '0))
        else $error("tick done or refusal with non-zero payload");

    a_slot_results_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_action == ACT_INIT || o_action == ACT_PAYLOAD
                         || o_action == ACT_CLEAN)) |-> !o_last)
        else $error("per-slot tick result marked final");

endmodule

@@ rtl/tss_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/tss_front.sv @@
// Task slot scheduler front end: classifies input items into commands and
// queues them two deep, dropping unknown codes. Depends on tss_pkg.
module tss_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [1:0]    i_func,
    input  logic [31:0]   i_time_delta,
    input  logic [31:0]   i_real_time,
    input  logic [3:0]    i_target_slot,
    input  logic [2:0]    i_new_state,
    input  logic [31:0]   i_wait_value,
    output logic          o_q_valid,
    output tss_pkg::t_cmd o_cmd,
    input  logic          i_q_pop
);
    import tss_pkg::*;

    t_cmd       r_ent [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_keep;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_keep       = 1'b1;
        w_cmd.delta  = i_time_delta;
        w_cmd.rt     = i_real_time;
        w_cmd.tslot  = i_target_slot;
        w_cmd.nstate = i_new_state;
        w_cmd.apply  = (i_new_state != NS_KEEP);
        w_cmd.wval   = i_wait_value;
        unique case (i_func)
            FN_TICK: w_cmd.kind = K_TICK;
            FN_LOAD: w_cmd.kind = K_LOAD;
            FN_SET:  w_cmd.kind = K_SET;
            default: begin
                w_cmd.kind = K_TICK;
                w_keep     = 1'b0;
            end
        endcase
    end

    assign o_in_stall = (r_cnt == 2'd2);
    assign w_push     = i_in_valid && !o_in_stall && w_keep;
    assign w_pop      = i_q_pop && (r_cnt != 2'd0);
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_cmd      = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ent[r_wp] <= w_cmd;
        end
    end

endmodule

@@ rtl/tss_back.sv @@
// Task slot scheduler back end: executes tick, load and set-state commands
// over the slot table and drives the result register. Depends on tss_pkg
// and tss_ram.
module tss_back #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [4:0]    i_slots_in_use,
    input  logic          i_q_valid,
    input  tss_pkg::t_cmd i_cmd,
    output logic          o_q_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [2:0]    o_action,
    output logic [3:0]    o_out_slot,
    output logic [31:0]   o_task_id,
    output logic [31:0]   o_elapsed,
    output logic [4:0]    o_occupied_count,
    output logic          o_last
);
    import tss_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = ($clog2(TABLE_DEPTH + 1) > 5) ? $clog2(TABLE_DEPTH + 1) : 5;
    localparam logic [CW-1:0] NS = CW'(TABLE_DEPTH);

    t_bstate                r_state, n_state;
    t_cmd                   r_cmd, n_cmd;
    logic [CW-1:0]          r_idx, n_idx;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [CW-1:0]          r_busy_cnt, n_busy_cnt;
    logic [31:0]            r_id, n_id;
    logic [TABLE_DEPTH-1:0] r_busy, n_busy;
    logic [TABLE_DEPTH-1:0] r_endf, n_endf;
    logic                   r_out_valid, n_out_valid;
    t_action                r_act, n_act;
    logic [3:0]             r_oslot, n_oslot;
    logic [31:0]            r_tid, n_tid;
    logic [31:0]            r_el, n_el;
    logic [CW-1:0]          r_occ, n_occ;
    logic                   r_last, n_last;

    logic [CW-1:0]          w_cfg;
    logic [CW-1:0]          w_m;
    logic [CW-1:0]          w_tslot;
    logic [IW-1:0]          w_pos;
    logic [IW-1:0]          w_tpos;
    logic                   w_idx_end;
    logic                   w_out_free;
    logic                   w_set_ok;
    logic [31:0]            w_id_inc;

    logic                   ram_we;
    logic [IW-1:0]          ram_waddr;
    t_slot_rec              ram_wdata;
    logic [IW-1:0]          ram_raddr;
    t_slot_rec              w_rec;

    logic [32:0]            w_sum;
    logic [31:0]            w_sat;
    logic [31:0]            w_wsub;
    logic [31:0]            w_wdec;
    t_slot_rec              w_tick_rec;
    t_action                w_tick_act;
    logic                   w_emit;

    tss_ram #(
        .WIDTH ($bits(t_slot_rec)),
        .DEPTH (TABLE_DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (w_rec)
    );

    assign w_cfg      = CW'(i_slots_in_use);
    assign w_m        = (w_cfg == '0) ? CW'(1) : ((w_cfg > NS) ? NS : w_cfg);
    assign w_tslot    = CW'(r_cmd.tslot);
    assign w_pos      = r_idx[IW-1:0];
    assign w_tpos     = w_tslot[IW-1:0];
    assign w_idx_end  = (r_idx >= w_m);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_set_ok   = (w_tslot < w_m) && r_busy[w_tpos];
    assign w_id_inc   = r_id + 32'd1;
    assign ram_raddr  = (r_cmd.kind == K_SET) ? w_tpos : w_pos;

    // per-slot tick step
    always_comb begin
        w_sum      = {1'b0, w_rec.elapsed} + {1'b0, r_cmd.delta};
        w_sat      = w_sum[32] ? '1 : w_sum[31:0];
        w_wsub     = (r_cmd.delta < w_rec.wait_amt) ? (w_rec.wait_amt - r_cmd.delta) : '0;
        w_wdec     = (w_rec.wait_amt != '0) ? (w_rec.wait_amt - 32'd1) : '0;
        w_tick_rec = w_rec;
        w_tick_rec.elapsed = w_sat;
        w_tick_act = ACT_DONE;
        w_emit     = 1'b0;
        unique case (w_rec.phase)
            PH_NEW: begin
                w_tick_rec.phase = PH_RUN;
                w_tick_act       = ACT_INIT;
                w_emit           = 1'b1;
            end
            PH_RUN: begin
                w_tick_rec.elapsed = '0;
                w_tick_act         = ACT_PAYLOAD;
                w_emit             = 1'b1;
            end
            PH_DELAY_T: begin
                w_tick_rec.wait_amt = w_wsub;
                if (w_wsub == '0) begin
                    w_tick_rec.phase = PH_RUN;
                end
            end
            PH_DELAY_C: begin
                w_tick_rec.wait_amt = w_wdec;
                if (w_wdec == '0) begin
                    w_tick_rec.phase = PH_RUN;
                end
            end
            PH_DELAY_M: begin
                if (r_cmd.rt >= w_rec.wait_amt) begin
                    w_tick_rec.phase = PH_RUN;
                end
            end
            PH_END: begin
                w_tick_rec = '0;
                w_tick_act = ACT_CLEAN;
                w_emit     = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_cmd.kind)
                        K_TICK:  n_state = ST_COUNT;
                        K_LOAD:  n_state = (r_busy_cnt >= w_m) ? ST_LOAD_FIN : ST_LOAD_SCAN;
                        K_SET:   n_state = ST_SET_RD;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_COUNT: begin
                if (w_idx_end) begin
                    n_state = ST_TICK_RD;
                end
            end
            ST_TICK_RD: begin
                priority if (w_idx_end) begin
                    n_state = ST_DONE;
                end else if (r_busy[w_pos]) begin
                    n_state = ST_TICK_EX;
                end
            end
            ST_TICK_EX: begin
                if (!w_emit || w_out_free) begin
                    n_state = ST_TICK_RD;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_LOAD_SCAN: begin
                if (w_idx_end || !r_busy[w_pos]) begin
                    n_state = ST_LOAD_FIN;
                end
            end
            ST_LOAD_FIN: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SET_RD: n_state = ST_SET_EX;
            ST_SET_EX: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_busy_cnt  = r_busy_cnt;
        n_id        = r_id;
        n_busy      = r_busy;
        n_endf      = r_endf;
        n_out_valid = w_out_free ? 1'b0 : r_out_valid;
        n_act       = r_act;
        n_oslot     = r_oslot;
        n_tid       = r_tid;
        n_el        = r_el;
        n_occ       = r_occ;
        n_last      = r_last;
        o_q_pop     = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = w_pos;
        ram_wdata   = w_tick_rec;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_cmd;
                    n_cnt   = r_busy_cnt;
                    n_idx   = (i_cmd.kind == K_LOAD && r_busy_cnt >= w_m) ? w_m : '0;
                end
            end
            ST_COUNT: begin
                if (w_idx_end) begin
                    n_idx = '0;
                end else begin
                    if (r_endf[w_pos]) begin
                        n_cnt = r_cnt - CW'(1);
                    end
                    n_idx = r_idx + CW'(1);
                end
            end
            ST_TICK_RD: begin
                if (!w_idx_end && !r_busy[w_pos]) begin
                    n_idx = r_idx + CW'(1);
                end
            end
            ST_TICK_EX: begin
                if (!w_emit || w_out_free) begin
                    ram_we = 1'b1;
                    n_idx  = r_idx + CW'(1);
                    if (w_tick_act == ACT_CLEAN) begin
                        n_busy[w_pos] = 1'b0;
                        n_endf[w_pos] = 1'b0;
                        if (r_busy_cnt != '0) begin
                            n_busy_cnt = r_busy_cnt - CW'(1);
                        end
                    end
                    if (w_emit) begin
                        n_out_valid = 1'b1;
                        n_act       = w_tick_act;
                        n_oslot     = r_idx[3:0];
                        n_tid       = w_rec.tid;
                        n_el        = w_sat;
                        n_occ       = r_cnt;
                        n_last      = 1'b0;
                    end
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_act       = ACT_DONE;
                    n_oslot     = '0;
                    n_tid       = '0;
                    n_el        = '0;
                    n_occ       = r_cnt;
                    n_last      = 1'b1;
                end
            end
            ST_LOAD_SCAN: begin
                if (!w_idx_end && r_busy[w_pos]) begin
                    n_idx = r_idx + CW'(1);
                end
            end
            ST_LOAD_FIN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_last      = 1'b1;
                    n_el        = '0;
                    if (!w_idx_end) begin
                        ram_we             = 1'b1;
                        ram_wdata.phase    = PH_NEW;
                        ram_wdata.wait_amt = '0;
                        ram_wdata.elapsed  = '0;
                        ram_wdata.tid      = r_id;
                        n_busy[w_pos]      = 1'b1;
                        n_endf[w_pos]      = 1'b0;
                        n_busy_cnt         = r_busy_cnt + CW'(1);
                        n_id               = (w_id_inc == '0) ? 32'd1 : w_id_inc;
                        n_act              = ACT_LOADED;
                        n_oslot            = r_idx[3:0];
                        n_tid              = r_id;
                        n_occ              = r_busy_cnt + CW'(1);
                    end else begin
                        n_act   = ACT_REFUSED;
                        n_oslot = '0;
                        n_tid   = '0;
                        n_occ   = r_busy_cnt;
                    end
                end
            end
            ST_SET_RD: begin
            end
            ST_SET_EX: begin
                if (w_out_free) begin
                    ram_waddr          = w_tpos;
                    ram_wdata.phase    = t_phase'(r_cmd.nstate);
                    ram_wdata.wait_amt = r_cmd.wval;
                    ram_wdata.elapsed  = w_rec.elapsed;
                    ram_wdata.tid      = w_rec.tid;
                    if (w_set_ok && r_cmd.apply) begin
                        ram_we         = 1'b1;
                        n_endf[w_tpos] = (t_phase'(r_cmd.nstate) == PH_END);
                    end
                    n_out_valid = 1'b1;
                    n_act       = ACT_SET;
                    n_oslot     = r_cmd.tslot;
                    n_tid       = w_set_ok ? w_rec.tid : '0;
                    n_el        = w_set_ok ? w_rec.elapsed : '0;
                    n_occ       = r_busy_cnt;
                    n_last      = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_busy_cnt  <= '0;
            r_id        <= 32'd1;
            r_busy      <= '0;
            r_endf      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_busy_cnt  <= n_busy_cnt;
            r_id        <= n_id;
            r_busy      <= n_busy;
            r_endf      <= n_endf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_act   <= n_act;
        r_oslot <= n_oslot;
        r_tid   <= n_tid;
        r_el    <= n_el;
        r_occ   <= n_occ;
        r_last  <= n_last;
    end

    assign o_out_valid      = r_out_valid;
    assign o_action         = r_act;
    assign o_out_slot       = r_oslot;
    assign o_task_id        = r_tid;
    assign o_elapsed        = r_el;
    assign o_occupied_count = r_occ[4:0];
    assign o_last           = r_last;

endmodule
